// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the gamepad report conditioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define ASSERT_HOLDS(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/gprac_pkg.sv =====
// Package of the gamepad report conditioner: types, codes, constants, byte maps.
`default_nettype none

package gprac_pkg;

  // Default sizing
  localparam int PAD_COUNT_DEF        = 4;
  localparam int MIN_REPORT_BYTES_DEF = 17;

  // Report layout
  localparam int CAPTURED_BYTES = 12;
  localparam int AXES           = 6;

  // Serial divider: quotient is at most 32768, which fits 16 bits; 17 bits are formed
  localparam int DIV_STEPS = 17;

  // Register indexes
  localparam logic [1:0] REG_STICK_DZ  = 2'd0;
  localparam logic [1:0] REG_TRIG_DZ   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [14:0] STICK_DZ_RESET  = 15'd4915;
  localparam logic [14:0] TRIG_DZ_RESET   = 15'd1638;
  localparam logic [14:0] THRESHOLD_RESET = 15'd328;

  // Axis codes, plus a slot for fetching the button word
  localparam logic [2:0] AXIS_RX      = 3'd0;
  localparam logic [2:0] AXIS_RY      = 3'd1;
  localparam logic [2:0] AXIS_LX      = 3'd2;
  localparam logic [2:0] AXIS_LY      = 3'd3;
  localparam logic [2:0] AXIS_LT      = 3'd4;
  localparam logic [2:0] AXIS_RT      = 3'd5;
  localparam logic [2:0] SLOT_BUTTONS = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_PREP,
    ST_DIVIDE,
    ST_POST,
    ST_EMIT
  } state_t;

  // Capture slot (report byte index minus one) of the low byte of each slot
  function automatic logic [3:0] lo_slot(input logic [2:0] axis);
    logic [3:0] s;
    unique case (axis)
      AXIS_RX: s = 4'd6;
      AXIS_RY: s = 4'd8;
      AXIS_LX: s = 4'd2;
      AXIS_LY: s = 4'd4;
      AXIS_LT: s = 4'd10;
      AXIS_RT: s = 4'd11;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic is_trigger(input logic [2:0] axis);
    return (axis == AXIS_LT) || (axis == AXIS_RT);
  endfunction

  function automatic logic is_y_axis(input logic [2:0] axis);
    return (axis == AXIS_RY) || (axis == AXIS_LY);
  endfunction

  // High byte slot; triggers are single bytes and re-read their own slot
  function automatic logic [3:0] hi_slot(input logic [2:0] axis);
    return is_trigger(axis) ? lo_slot(axis) : lo_slot(axis) + 4'd1;
  endfunction

endpackage

`default_nettype wire

// ===== src/gamepad_report_axis_conditioner.sv =====
// Top level: report capture, deadzone scaling by serial division, axis change events.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------------
//  item      | item_valid / item_ready  | kind, pad, report_byte, last_byte
//  event     | event_valid / event_ready| pad_id, changed_axis, sticks, triggers,
//            |                          | button_bits, timestamp, last
//  config    | cfg_write (no wait)      | cfg_index, cfg_data
//
// A tick or a non-final report byte leaves the sequencer idle. The final byte of a
// report of full length holds the item channel while each axis in turn gets two
// capture memory reads, set-up, the 17 steps of the one-bit-per-cycle divider
// and write-back to the axis store; the button word then gets the reads and
// set-up, and event words follow, one per moved axis. Reset is synchronous;
// the axis store reads as zero per pad until its first report completes, no
// clearing pass. A stalled event word holds the whole block.
`default_nettype none
`include "assert_macros.svh"

module gamepad_report_axis_conditioner import gprac_pkg::*; #(
  parameter int PAD_COUNT        = PAD_COUNT_DEF,
  parameter int MIN_REPORT_BYTES = MIN_REPORT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               kind,
  input  logic [1:0]         pad,
  input  logic [7:0]         report_byte,
  input  logic               last_byte,
  // event channel
  output logic               event_valid,
  input  logic               event_ready,
  output logic [1:0]         pad_id,
  output logic [2:0]         changed_axis,
  output logic signed [15:0] right_stick_x,
  output logic signed [15:0] right_stick_y,
  output logic signed [15:0] left_stick_x,
  output logic signed [15:0] left_stick_y,
  output logic [14:0]        left_trigger,
  output logic [14:0]        right_trigger,
  output logic [15:0]        button_bits,
  output logic [31:0]        timestamp,
  output logic               last,
  // configuration
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int PAD_W     = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int PAD_SLOTS = 2 ** PAD_W;
  localparam int POS_W     = $clog2(MIN_REPORT_BYTES + 1);
  localparam int CAP_AW    = PAD_W + 4;
  localparam int AXIS_AW   = PAD_W + 3;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [POS_W-1:0] MIN_POS  = POS_W'(MIN_REPORT_BYTES);
  localparam logic [POS_W-1:0] CAP_LAST = POS_W'(CAPTURED_BYTES);

  // Configuration registers
  logic [14:0] stick_dz;
  logic [14:0] trig_dz;
  logic [14:0] change_threshold;

  // Control state
  state_t                 state, state_next;
  logic [31:0]            frame_counter;
  logic [POS_W-1:0]       byte_position [PAD_SLOTS];
  logic [PAD_SLOTS-1:0]   store_valid;
  logic [1:0]             pad_reg;
  logic [2:0]             slot;
  logic [AXES-1:0]        moved_mask;

  // Datapath registers
  logic [7:0]             lo_byte;
  logic [15:0]            buttons;
  logic                   div_neg;
  logic [29:0]            div_rem;
  logic [16:0]            div_num;
  logic [29:0]            div_d;
  logic [16:0]            div_q;
  logic [CNT_W-1:0]       div_count;
  logic [15:0]            nv [AXES];

  // Memories
  logic [7:0]             cap_mem  [2 ** CAP_AW];
  logic [7:0]             cap_rdata;
  logic [15:0]            axis_mem [2 ** AXIS_AW];
  logic [15:0]            axis_rdata;

  // Memory controls
  logic                   cap_rd_en;
  logic [3:0]             cap_rd_slot;
  logic                   axis_rd_en;
  logic                   axis_we;

  // ---------------------------------------------------------------
  // Input side: pad decode and byte counting
  logic [PAD_W+1:0]       pad_ext;
  logic [PAD_W-1:0]       in_idx;
  logic [PAD_W+1:0]       pad_reg_ext;
  logic [PAD_W-1:0]       pad_idx;
  logic                   pad_ok;
  logic                   item_fire;
  logic                   byte_fire;
  logic [POS_W-1:0]       cur_pos;
  logic [POS_W:0]         pos_inc;
  logic [POS_W-1:0]       count;
  logic                   cap_we;
  logic [3:0]             cap_wr_slot;
  logic                   report_full;

  assign pad_ext     = (PAD_W + 2)'(pad);
  assign in_idx      = pad_ext[PAD_W-1:0];
  assign pad_reg_ext = (PAD_W + 2)'(pad_reg);
  assign pad_idx     = pad_reg_ext[PAD_W-1:0];
  assign pad_ok      = 32'(pad) < PAD_COUNT;
  assign item_fire   = item_valid && item_ready;
  assign byte_fire   = item_fire && kind && pad_ok;
  assign cur_pos     = byte_position[in_idx];
  assign pos_inc     = {1'b0, cur_pos} + (POS_W + 1)'(1);
  assign count       = (pos_inc >= {1'b0, MIN_POS}) ? MIN_POS : pos_inc[POS_W-1:0];
  assign cap_we      = byte_fire && (cur_pos != '0) && (cur_pos <= CAP_LAST);
  assign cap_wr_slot = 4'(cur_pos - POS_W'(1));
  assign report_full = byte_fire && last_byte && (count == MIN_POS);

  // ---------------------------------------------------------------
  // Set-up of one division from the fetched bytes
  logic [15:0] word;
  logic [15:0] inv_s, inv_t;
  logic [30:0] d_stick_w;
  logic [29:0] a_s, t_s;
  logic [15:0] m_neg;
  logic [22:0] a_t, t_t;
  logic [23:0] d_trig_w;
  logic [29:0] prep_x, prep_d;
  logic        prep_neg;

  assign word      = {cap_rdata, lo_byte};
  assign inv_s     = 16'(17'd32768 - {2'b0, stick_dz});
  assign inv_t     = 16'(17'd32768 - {2'b0, trig_dz});
  assign d_stick_w = ({15'b0, inv_s} << 15) - {15'b0, inv_s};
  assign a_s       = {word[14:0], 15'b0};
  assign t_s       = ({15'b0, stick_dz} << 15) - {15'b0, stick_dz};
  assign m_neg     = ~word + 16'd1;
  assign a_t       = {lo_byte, 15'b0};
  assign t_t       = ({8'b0, trig_dz} << 8) - {8'b0, trig_dz};
  assign d_trig_w  = ({8'b0, inv_t} << 8) - {8'b0, inv_t};

  always_comb begin
    priority if (is_trigger(slot)) begin
      prep_neg = 1'b0;
      prep_x   = (a_t >= t_t) ? 30'(a_t - t_t) : '0;
      prep_d   = 30'(d_trig_w);
    end else if (!word[15]) begin
      prep_neg = 1'b0;
      prep_x   = (a_s >= t_s) ? a_s - t_s : '0;
      prep_d   = d_stick_w[29:0];
    end else begin
      prep_neg = 1'b1;
      prep_x   = (m_neg >= {1'b0, stick_dz}) ?
                 30'(m_neg - {1'b0, stick_dz}) : '0;
      prep_d   = 30'(inv_s);
    end
  end

  // ---------------------------------------------------------------
  // Restoring divider step
  logic [31:0] div_trial;
  logic        div_ge;

  assign div_trial = {1'b0, div_rem, div_num[16]} - {2'b0, div_d};
  assign div_ge    = !div_trial[31];

  // ---------------------------------------------------------------
  // Sign, saturation and change test
  logic        out_neg;
  logic [15:0] pos_val, neg_val, new_val, old_val;
  logic [16:0] delta, abs_delta;
  logic        moved;

  assign out_neg   = div_neg ^ is_y_axis(slot);
  assign pos_val   = div_q[15] ? 16'h7FFF : div_q[15:0];
  assign neg_val   = 16'(17'd0 - div_q);
  assign new_val   = out_neg ? neg_val : pos_val;
  assign old_val   = store_valid[pad_idx] ? axis_rdata : 16'd0;
  assign delta     = {new_val[15], new_val} - {old_val[15], old_val};
  assign abs_delta = delta[16] ? 17'd0 - delta : delta;
  assign moved     = abs_delta > {2'b0, change_threshold};

  // ---------------------------------------------------------------
  // Event selection: lowest pending axis
  logic [2:0]      emit_axis;
  logic [AXES-1:0] emit_onehot;

  always_comb begin
    emit_axis   = '0;
    emit_onehot = '0;
    for (int i = AXES - 1; i >= 0; i--) begin
      if (moved_mask[i]) begin
        emit_axis   = 3'(i);
        emit_onehot = AXES'(1) << i;
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (report_full) state_next = ST_FETCH_LO;
      ST_FETCH_LO: state_next = ST_FETCH_HI;
      ST_FETCH_HI: state_next = ST_PREP;
      ST_PREP: begin
        if (slot == SLOT_BUTTONS) begin
          state_next = (moved_mask != '0) ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE:   if (div_count == '0) state_next = ST_POST;
      ST_POST:     state_next = ST_FETCH_LO;
      ST_EMIT:     if (event_ready && last) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs and memory controls
  always_comb begin
    item_ready  = 1'b0;
    event_valid = 1'b0;
    cap_rd_en   = 1'b0;
    cap_rd_slot = lo_slot(slot);
    axis_rd_en  = 1'b0;
    axis_we     = 1'b0;
    unique case (state)
      ST_IDLE:     item_ready = 1'b1;
      ST_FETCH_LO: cap_rd_en  = 1'b1;
      ST_FETCH_HI: begin
        cap_rd_en   = 1'b1;
        cap_rd_slot = hi_slot(slot);
      end
      ST_PREP:     axis_rd_en = 1'b1;
      ST_DIVIDE:   ;
      ST_POST:     axis_we    = 1'b1;
      ST_EMIT:     event_valid = 1'b1;
      default:     ;
    endcase
  end

  // ---------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stick_dz         <= STICK_DZ_RESET;
      trig_dz          <= TRIG_DZ_RESET;
      change_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STICK_DZ:  stick_dz         <= cfg_data;
        REG_TRIG_DZ:   trig_dz          <= cfg_data;
        REG_THRESHOLD: change_threshold <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_counter <= '0;
      store_valid   <= '0;
      moved_mask    <= '0;
      slot          <= '0;
      pad_reg       <= '0;
      for (int i = 0; i < PAD_SLOTS; i++) byte_position[i] <= '0;
    end else begin
      state <= state_next;
      if (item_fire && !kind) frame_counter <= frame_counter + 32'd1;
      if (byte_fire) byte_position[in_idx] <= last_byte ? '0 : count;
      if (report_full) begin
        pad_reg    <= pad;
        slot       <= '0;
        moved_mask <= '0;
      end
      if (state == ST_POST) begin
        slot             <= slot + 3'd1;
        moved_mask[slot] <= moved;
        if (slot == AXIS_RT) store_valid[pad_idx] <= 1'b1;
      end
      if (event_valid && event_ready) moved_mask <= moved_mask & ~emit_onehot;
    end
  end

  // Datapath: byte latch, divider, results
  always_ff @(posedge clk) begin
    if (state == ST_FETCH_HI) lo_byte <= cap_rdata;
    if (state == ST_PREP) begin
      if (slot == SLOT_BUTTONS) buttons <= word;
      div_neg   <= prep_neg;
      div_rem   <= {2'b0, prep_x[29:2]};
      div_num   <= {prep_x[1:0], 15'b0};
      div_d     <= prep_d;
      div_q     <= '0;
      div_count <= CNT_W'(DIV_STEPS - 1);
    end
    if (state == ST_DIVIDE) begin
      div_rem   <= div_ge ? div_trial[29:0] : {div_rem[28:0], div_num[16]};
      div_num   <= {div_num[15:0], 1'b0};
      div_q     <= {div_q[15:0], div_ge};
      div_count <= div_count - CNT_W'(1);
    end
    if (state == ST_POST) nv[slot] <= new_val;
  end

  // Capture memory: written on byte arrival, read in the fetch states
  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[{in_idx, cap_wr_slot}] <= report_byte;
    if (cap_rd_en) cap_rdata <= cap_mem[{pad_idx, cap_rd_slot}];
  end

  // Axis store: read in set-up, written back after the divide
  always_ff @(posedge clk) begin
    if (axis_we) axis_mem[{pad_idx, slot}] <= new_val;
    if (axis_rd_en) axis_rdata <= axis_mem[{pad_idx, slot}];
  end

  // ---------------------------------------------------------------
  // Event word
  assign pad_id        = pad_reg;
  assign changed_axis  = emit_axis;
  assign right_stick_x = nv[AXIS_RX];
  assign right_stick_y = nv[AXIS_RY];
  assign left_stick_x  = nv[AXIS_LX];
  assign left_stick_y  = nv[AXIS_LY];
  assign left_trigger  = nv[AXIS_LT][14:0];
  assign right_trigger = nv[AXIS_RT][14:0];
  assign button_bits   = buttons;
  assign timestamp     = frame_counter;
  assign last          = (moved_mask & ~emit_onehot) == '0;

  // ---------------------------------------------------------------
  // Checks
  `ASSERT_HOLDS(a_rem_below_divisor, clk, rst, state == ST_DIVIDE, div_rem < div_d)
  `ASSERT_HOLDS(a_quotient_bound, clk, rst, state == ST_POST, div_q <= 17'd32768)
  `ASSERT_HOLDS(a_emit_has_axis, clk, rst, event_valid, moved_mask != '0)
  `ASSERT_NEXT(a_final_frees_input, clk, rst, event_valid && event_ready && last, item_ready)
  `ASSERT_NEXT(a_axis_order, clk, rst, event_valid && event_ready && !last, event_valid && (changed_axis > $past(changed_axis)))

endmodule

`default_nettype wire

// ===== tb/sv/gamepad_report_axis_conditioner_tb.sv =====
// Self-checking testbench of the gamepad report conditioner: directed reports, then random streams.
module gamepad_report_axis_conditioner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gprac_pkg::*;

  localparam logic       KIND_TICK     = 1'b0;
  localparam logic       KIND_BYTE     = 1'b1;
  localparam logic [1:0] REG_SPARE     = 2'd3;   // unmapped index, writes are dropped
  localparam int         SETTLE_CYCLES = 200;    // outlasts the work on a final byte without events
  localparam int         LONG_HOLD     = 400;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         RANDOM_ITEMS  = 130;
  localparam int         PHASE_ITEMS   = 65;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [1:0]         pad_id;
    logic [2:0]         axis;
    logic signed [15:0] rsx;
    logic signed [15:0] rsy;
    logic signed [15:0] lsx;
    logic signed [15:0] lsy;
    logic [14:0]        lt;
    logic [14:0]        rt;
    logic [15:0]        buttons;
    logic [31:0]        stamp;
    logic               is_last;
  } pad_event_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               item_valid  = 1'b0;
  logic               item_ready;
  logic               kind        = 1'b0;
  logic [1:0]         pad         = 2'd0;
  logic [7:0]         report_byte = 8'd0;
  logic               last_byte   = 1'b0;
  logic               event_valid;
  logic               event_ready = 1'b0;
  logic [1:0]         pad_id;
  logic [2:0]         changed_axis;
  logic signed [15:0] right_stick_x;
  logic signed [15:0] right_stick_y;
  logic signed [15:0] left_stick_x;
  logic signed [15:0] left_stick_y;
  logic [14:0]        left_trigger;
  logic [14:0]        right_trigger;
  logic [15:0]        button_bits;
  logic [31:0]        timestamp;
  logic               last;
  logic               cfg_write   = 1'b0;
  logic [1:0]         cfg_index   = 2'd0;
  logic [14:0]        cfg_data    = 15'd0;

  // Mirror of the block state and registers
  logic [4:0]  fill_pos    [PAD_COUNT_DEF];
  logic [7:0]  capture_mem [PAD_COUNT_DEF][CAPTURED_BYTES];
  int          axis_mem    [PAD_COUNT_DEF][AXES];
  logic [15:0] button_mem  [PAD_COUNT_DEF];
  logic [31:0] tick_total;
  logic [14:0] stick_dz;
  logic [14:0] trig_dz;
  logic [14:0] move_threshold;

  pad_event_t pending_events[$];

  // Run bookkeeping
  int  mismatch_count  = 0;
  int  cycle_count     = 0;
  int  items_accepted  = 0;
  int  tick_words      = 0;
  int  full_reports    = 0;
  int  dropped_reports = 0;
  int  expected_events = 0;
  int  event_words     = 0;
  int  settings_count  = 0;
  bit  sender_idle     = 1'b1;
  bit  rx_idle         = 1'b1;
  int  hold_requests   = 0;
  int  holds_served    = 0;
  int  hold_left       = 0;
  int  rx_stall        = 0;

  gamepad_report_axis_conditioner u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[gamepad_report_axis_conditioner] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic int clamp_q15(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Asymmetric normalisation and axial deadzone, unsaturated magnitude with sign
  function automatic int scale_stick(input logic [15:0] w, input logic [14:0] dz);
    longint r, d, a, t, mag;
    r = longint'($signed(w));
    d = longint'(dz);
    if (r == 0) return 0;
    if (r > 0) begin
      a = r * 32768;
      t = d * 32767;
      if (a < t) return 0;
      mag = ((a - t) * 32768) / (32767 * (32768 - d));
      return int'(mag);
    end
    if (-r < d) return 0;
    mag = ((-r - d) * 32768) / (32768 - d);
    return -int'(mag);
  endfunction

  function automatic int scale_trigger(input logic [7:0] b, input logic [14:0] dz);
    longint d, a, t, mag;
    d = longint'(dz);
    a = longint'(b) * 32768;
    t = d * 255;
    if (a < t) return 0;
    mag = ((a - t) * 32768) / (255 * (32768 - d));
    if (mag > 32767) mag = 32767;
    return int'(mag);
  endfunction

  // Little-endian word whose low byte is report byte idx
  function automatic logic [15:0] report_word(input logic [1:0] p, input int idx);
    return {capture_mem[p][idx], capture_mem[p][idx - 1]};
  endfunction

  task automatic reset_mirror();
    stick_dz       = STICK_DZ_RESET;
    trig_dz        = TRIG_DZ_RESET;
    move_threshold = THRESHOLD_RESET;
    tick_total     = '0;
    for (int p = 0; p < PAD_COUNT_DEF; p++) begin
      fill_pos[p]   = '0;
      button_mem[p] = '0;
      for (int i = 0; i < CAPTURED_BYTES; i++) capture_mem[p][i] = '0;
      for (int a = 0; a < AXES; a++) axis_mem[p][a] = 0;
    end
  endtask

  // Applies one accepted item word and queues the events it causes
  task automatic track_report_word(input logic k, input logic [1:0] p, input logic [7:0] b,
                                   input logic fin);
    int         count;
    int         moved_total;
    int         emitted;
    int         diff;
    int         nv [AXES];
    bit         moved [AXES];
    pad_event_t e;
    if (k == KIND_TICK) begin
      tick_total++;
      tick_words++;
      return;
    end
    if (fill_pos[p] >= 1 && fill_pos[p] <= CAPTURED_BYTES) capture_mem[p][fill_pos[p] - 1] = b;
    count = fill_pos[p] + 1;
    if (count > MIN_REPORT_BYTES_DEF) count = MIN_REPORT_BYTES_DEF;
    if (!fin) begin
      fill_pos[p] = 5'(count);
      return;
    end
    fill_pos[p] = '0;
    if (count < MIN_REPORT_BYTES_DEF) begin
      dropped_reports++;
      return;
    end
    full_reports++;

    nv[AXIS_RX] = clamp_q15(scale_stick(report_word(p, 7), stick_dz));
    nv[AXIS_RY] = clamp_q15(-scale_stick(report_word(p, 9), stick_dz));
    nv[AXIS_LX] = clamp_q15(scale_stick(report_word(p, 3), stick_dz));
    nv[AXIS_LY] = clamp_q15(-scale_stick(report_word(p, 5), stick_dz));
    nv[AXIS_LT] = scale_trigger(capture_mem[p][10], trig_dz);
    nv[AXIS_RT] = scale_trigger(capture_mem[p][11], trig_dz);

    // Change detection against the stored axes, stores take the new values
    moved_total = 0;
    for (int a = 0; a < AXES; a++) begin
      diff = nv[a] - axis_mem[p][a];
      if (diff < 0) diff = -diff;
      moved[a] = diff > int'(move_threshold);
      if (moved[a]) moved_total++;
      axis_mem[p][a] = nv[a];
    end
    button_mem[p] = report_word(p, 1);

    emitted = 0;
    for (int a = 0; a < AXES; a++) begin
      if (moved[a]) begin
        emitted++;
        e.pad_id  = p;
        e.axis    = 3'(a);
        e.rsx     = nv[AXIS_RX][15:0];
        e.rsy     = nv[AXIS_RY][15:0];
        e.lsx     = nv[AXIS_LX][15:0];
        e.lsy     = nv[AXIS_LY][15:0];
        e.lt      = nv[AXIS_LT][14:0];
        e.rt      = nv[AXIS_RT][14:0];
        e.buttons = button_mem[p];
        e.stamp   = tick_total;
        e.is_last = (emitted == moved_total);
        pending_events.push_back(e);
        expected_events++;
      end
    end
  endtask

  // ---------------------------------------------------------------- event side

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_event_word();
    pad_event_t e;
    event_words++;
    if (pending_events.size() == 0) begin
      $error("event word with nothing expected: pad %0d axis %0d", pad_id, changed_axis);
      mismatch_count++;
      return;
    end
    e = pending_events.pop_front();
    compare_field("pad_id", e.pad_id, pad_id);
    compare_field("changed_axis", e.axis, changed_axis);
    compare_field("right_stick_x", e.rsx, right_stick_x);
    compare_field("right_stick_y", e.rsy, right_stick_y);
    compare_field("left_stick_x", e.lsx, left_stick_x);
    compare_field("left_stick_y", e.lsy, left_stick_y);
    compare_field("left_trigger", e.lt, left_trigger);
    compare_field("right_trigger", e.rt, right_trigger);
    compare_field("button_bits", e.buttons, button_bits);
    compare_field("timestamp", e.stamp, timestamp);
    compare_field("last", e.is_last, last);
  endtask

  // Receiver: checks each word, random stalls, and long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      event_ready <= 1'b0;
    end else begin
      if (event_valid && event_ready) begin
        check_event_word();
        rx_stall = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        event_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        event_ready <= 1'b0;
      end else begin
        event_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- item side

  task automatic send_word(input logic k, input logic [1:0] p, input logic [7:0] b,
                           input logic fin);
    int gap;
    gap = sender_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    pad         <= p;
    report_byte <= b;
    last_byte   <= fin;
    do @(posedge clk); while (!item_ready);
    items_accepted++;
    track_report_word(k, p, b, fin);
  endtask

  function automatic byte_q_t build_report(input logic [15:0] btn, lx, ly, rx, ry,
                                           input logic [7:0] lt, rt, input int len);
    byte_q_t q;
    q = '{8'($urandom), btn[7:0], btn[15:8], lx[7:0], lx[15:8], ly[7:0], ly[15:8],
          rx[7:0], rx[15:8], ry[7:0], ry[15:8], lt, rt};
    while (q.size() < len) q.push_back(8'($urandom));
    while (q.size() > len) void'(q.pop_back());
    return q;
  endfunction

  task automatic send_report(input logic [1:0] p, input byte_q_t q);
    foreach (q[i]) send_word(KIND_BYTE, p, q[i], i == q.size() - 1);
  endtask

  // Wait until every expected word is out and the block has gone quiet
  task automatic settle_block();
    item_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All three registers, then a write to the unmapped index
  task automatic program_registers(input logic [14:0] s, t, th);
    cfg_write <= 1'b1;
    cfg_index <= REG_STICK_DZ;
    cfg_data  <= s;
    @(posedge clk);
    stick_dz = s;
    cfg_index <= REG_TRIG_DZ;
    cfg_data  <= t;
    @(posedge clk);
    trig_dz = t;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= th;
    @(posedge clk);
    move_threshold = th;
    cfg_index <= REG_SPARE;
    cfg_data  <= 15'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [14:0] pick_setting(input logic [14:0] dflt, input int top);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 15'h7FFF;
      2:       return dflt;
      default: return 15'($urandom_range(0, top));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset settings: full-scale report, repeat with no change, short and long reports
  task automatic test_defaults_and_edges();
    send_word(KIND_TICK, 2'd3, 8'hFF, 1'b1);
    send_report(2'd0, build_report(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                                   8'hFF, 8'h00, 17));
    send_report(2'd0, build_report(16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                                   8'hFF, 8'h00, 17));
    send_report(2'd1, build_report(16'h1234, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
                                   8'h80, 8'h80, 4));
    send_word(KIND_TICK, 2'd0, 8'h00, 1'b0);
    // values right on and just inside the deadzones, longer than the minimum
    send_report(2'd2, build_report(16'hA55A, 16'h1333, 16'hECCD, 16'h1332, 16'hECCE,
                                   8'h0D, 8'h0C, 24));
  endtask

  // Zero deadzones and threshold: full scale saturates, every move is an event
  task automatic test_zero_deadzone();
    settle_block();
    program_registers('0, '0, '0);
    send_report(2'd3, build_report(16'h0001, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                                   8'hFF, 8'h01, 17));
    send_word(KIND_TICK, 2'd1, 8'h55, 1'b1);
    send_report(2'd3, build_report(16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000,
                                   8'h00, 8'h00, 18));
  endtask

  // Largest deadzones: only full scale gets through, one step below is zero
  task automatic test_full_deadzone();
    settle_block();
    program_registers(15'h7FFF, 15'h7FFF, '0);
    send_report(2'd1, build_report(16'h00FF, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFE,
                                   8'hFF, 8'hFE, 17));
  endtask

  // Largest threshold: only a full swing of a stick is reported
  task automatic test_max_threshold();
    settle_block();
    program_registers(STICK_DZ_RESET, TRIG_DZ_RESET, 15'h7FFF);
    send_report(2'd0, build_report(16'h0F0F, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                                   8'h00, 8'hFF, 17));
  endtask

  // Interleaved reports on all pads with random content and settings per phase
  task automatic test_random_streams();
    int          phase;
    int          sent;
    int          pick;
    logic [1:0]  p;
    logic [7:0]  b;
    int          left [PAD_COUNT_DEF];
    int          pos  [PAD_COUNT_DEF];
    logic [7:0]  prev [PAD_COUNT_DEF][32];
    logic [7:0]  edge_bytes [5] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01};
    phase        = 0;
    sent         = 0;
    for (int i = 0; i < PAD_COUNT_DEF; i++) begin
      left[i] = 0;
      pos[i]  = 0;
      for (int j = 0; j < 32; j++) prev[i][j] = 8'($urandom);
    end
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      program_registers(pick_setting(STICK_DZ_RESET, 32767),
                        pick_setting(TRIG_DZ_RESET, 32767),
                        pick_setting(THRESHOLD_RESET, 1500));
      // block fills up behind a stalled event side
      if (phase == 1) hold_requests <= hold_requests + 1;
      repeat (PHASE_ITEMS) begin
        if (sent % 16 == 0) begin
          sender_idle = $urandom_range(0, 2) != 0;
          rx_idle    <= $urandom_range(0, 2) != 0;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_word(KIND_TICK, 2'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          p = 2'($urandom);
          if (left[p] == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      left[p] = $urandom_range(17, 20);
            else if (pick < 92) left[p] = $urandom_range(1, 16);
            else                left[p] = $urandom_range(21, 30);
            pos[p] = 0;
          end
          // partly near the previous report, so small moves meet the threshold
          case ($urandom_range(0, 9))
            0, 1:    b = prev[p][pos[p]];
            2:       b = prev[p][pos[p]] + 8'($urandom_range(0, 2));
            3, 4:    b = edge_bytes[$urandom_range(0, 4)];
            default: b = 8'($urandom);
          endcase
          prev[p][pos[p]] = b;
          send_word(KIND_BYTE, p, b, left[p] == 1);
          left[p]--;
          pos[p]++;
        end
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    reset_mirror();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_defaults_and_edges();
    test_zero_deadzone();
    test_full_deadzone();
    test_max_threshold();
    test_random_streams();
    settle_block();

    $display("Run covered %0d item words: %0d full reports, %0d dropped short reports, %0d ticks.",
             items_accepted, full_reports, dropped_reports, tick_words);
    $display("Checked %0d of %0d expected event words over %0d register settings, %0d mismatches.",
             event_words, expected_events, settings_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[gamepad_report_axis_conditioner] OK");
    end else begin
      $display("[gamepad_report_axis_conditioner] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/gprac_pkg.sv
src/gamepad_report_axis_conditioner.sv
tb/sv/gamepad_report_axis_conditioner_tb.sv
